// ===== hdl/nsfe_pkg.sv =====
package nsfe_pkg;

   localparam int CHAR_W  = 8;
   localparam int COUNT_W = 7;
   localparam int TAG_W   = 40;
   localparam int POS_W   = 5;
   localparam int LEN_W   = 3;
   localparam int CSR_W   = 40;
   localparam int CSR_IDX_W = 2;

   localparam logic [CHAR_W-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0D;
   localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2C;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TAG_CHARS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TAG_LENGTH    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FIELD_INDEX   = 2'd3;

   // Reset tag is "GPGGA".
   localparam logic [TAG_W-1:0] TAG_RESET = 40'h4750474741;
   localparam logic [LEN_W-1:0] TAG_LENGTH_RESET = 3'd5;

   typedef struct packed {
      logic take;   // input transaction accepted this cycle
      logic rd;     // read field store at the emit index
      logic load;   // load the result register
      logic inc;    // advance the emit index
   } cmd_type;

   typedef struct packed {
      logic emit_start;  // current character ends an accepted sentence
      logic last;        // emit index points at the final result
   } sts_type;

endpackage

// ===== hdl/nmea_sentence_field_extractor.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_ready  req_rx_byte
// rsp_      out        rsp_valid/rsp_ready  rsp_field_char, rsp_char_position,
//                                           rsp_last_char, rsp_field_empty,
//                                           rsp_field_truncated
// csr_      in         csr_write_enable     csr_index, csr_write_data
//
// A received character is taken whenever one is offered while no sentence is being emitted.
// At sentence end each field character takes a field store read through its
// registered port, then a load of the result register.
// Reset is synchronous and active high; the block starts hunting for a dollar.
// The field store needs no clearing pass after reset.
// A stalled result holds the emitter; input is taken again once the final result
// of the sentence sits in the result register.
module nmea_sentence_field_extractor import nsfe_pkg::*; #(
   parameter int LINE_MAX  = 128,
   parameter int FIELD_MAX = 32,
   parameter int TAG_MAX   = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CHAR_W-1:0]    req_rx_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CHAR_W-1:0]    rsp_field_char,
   output logic [POS_W-1:0]     rsp_char_position,
   output logic                 rsp_last_char,
   output logic                 rsp_field_empty,
   output logic                 rsp_field_truncated,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   // Commands from the controller drive the datapath; the datapath reports when
   // an input transaction closes an accepted sentence and when emission is done.
   cmd_type cmd;
   sts_type sts;

   nsfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the configuration registers, the sentence scanner with
   // its tag window, the field store memory and the result register.
   nsfe_datapath #(
      .LINE_MAX  (LINE_MAX),
      .FIELD_MAX (FIELD_MAX),
      .TAG_MAX   (TAG_MAX)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_rx_byte         (req_rx_byte),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_field_char      (rsp_field_char),
      .rsp_char_position   (rsp_char_position),
      .rsp_last_char       (rsp_last_char),
      .rsp_field_empty     (rsp_field_empty),
      .rsp_field_truncated (rsp_field_truncated)
   );

endmodule

// ===== hdl/nsfe_ctrl.sv =====
module nsfe_ctrl import nsfe_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [1:0] {
      S_RUN,
      S_READ,
      S_LOAD
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == S_RUN);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_RUN: begin
            cmd.take = req_valid;
            if (req_valid && sts.emit_start) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (out_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (sts.last) begin
                  state_in = S_RUN;
               end else begin
                  cmd.inc  = 1'b1;
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A result is loaded only after its store read has been issued.
   a_load_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LOAD |-> $past(state_ff) == S_READ || $past(state_ff) == S_LOAD)
      else $error("load state entered without a store read");

endmodule

// ===== hdl/nsfe_datapath.sv =====
module nsfe_datapath import nsfe_pkg::*; #(
   parameter int LINE_MAX  = 128,
   parameter int FIELD_MAX = 32,
   parameter int TAG_MAX   = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data,
   input  logic [CHAR_W-1:0]    req_rx_byte,
   input  cmd_type              cmd,
   output sts_type              sts,
   output logic [CHAR_W-1:0]    rsp_field_char,
   output logic [POS_W-1:0]     rsp_char_position,
   output logic                 rsp_last_char,
   output logic                 rsp_field_empty,
   output logic                 rsp_field_truncated
);

   localparam int AW   = (FIELD_MAX > 1) ? $clog2(FIELD_MAX) : 1;
   localparam int FL_W = $clog2(FIELD_MAX + 1);
   localparam logic [COUNT_W:0]   LINE_LIMIT  = LINE_MAX[COUNT_W:0];
   localparam logic [FL_W-1:0]    FIELD_LIMIT = FIELD_MAX[FL_W-1:0];
   localparam logic [LEN_W-1:0]   TAG_LIMIT   = TAG_MAX[LEN_W-1:0];
   localparam logic [COUNT_W-1:0] COUNT_SAT   = '1;

   // Configuration registers.
   logic                filter_enable_ff;
   logic [TAG_W-1:0]    tag_chars_ff;
   logic [LEN_W-1:0]    tag_length_ff;
   logic [COUNT_W-1:0]  field_index_ff;

   // Sentence state.
   logic                hunting_ff, hunting_in;
   logic [COUNT_W-1:0]  stored_count_ff, stored_count_in;
   logic [COUNT_W-1:0]  comma_count_ff, comma_count_in;
   logic [FL_W-1:0]     field_length_ff, field_length_in;
   logic                overflow_ff, overflow_in;
   logic [31:0]         recent_ff, recent_in;
   logic                tag_found_ff, tag_found_in;

   logic [CHAR_W-1:0]   field_store [FIELD_MAX];
   logic [CHAR_W-1:0]   rd_data_ff;
   logic [AW-1:0]       idx_ff, idx_in;

   logic [CHAR_W-1:0]   char_ff;
   logic [POS_W-1:0]    pos_ff;
   logic                last_ff, empty_ff, trunc_ff;

   logic [CHAR_W-1:0]   c;
   logic                starting, ending, do_store, emit_ok, store_we, tag_hit;
   logic [LEN_W-1:0]    len_used;
   logic [COUNT_W-1:0]  sc_base, cc_base;
   logic [FL_W-1:0]     fl_base;
   logic                ov_base, tf_base;
   logic [31:0]         rc_base;
   logic [TAG_W-1:0]    window;

   assign c        = req_rx_byte;
   assign len_used = (tag_length_ff > TAG_LIMIT) ? TAG_LIMIT : tag_length_ff;
   assign starting = hunting_ff && (c == CHAR_DOLLAR);
   assign ending   = !hunting_ff &&
                     ((c == CHAR_CR) || ({1'b0, stored_count_ff} + 1'b1 >= LINE_LIMIT));
   assign do_store = cmd.take && (starting || (!hunting_ff && !ending));
   assign emit_ok  = !filter_enable_ff || tag_found_ff || (len_used == '0);

   assign sts.emit_start = ending && emit_ok;
   assign sts.last = (field_length_ff == '0) ||
                     ({{(FL_W-AW){1'b0}}, idx_ff} + 1'b1 == field_length_ff);

   // A new sentence starts from cleared state and then stores its dollar.
   assign sc_base = starting ? '0 : stored_count_ff;
   assign cc_base = starting ? '0 : comma_count_ff;
   assign fl_base = starting ? '0 : field_length_ff;
   assign ov_base = starting ? 1'b0 : overflow_ff;
   assign rc_base = starting ? '0 : recent_ff;
   assign tf_base = starting ? 1'b0 : tag_found_ff;
   assign window  = {rc_base, c};

   always_comb begin
      case (len_used)
         3'd1:    tag_hit = (window[7:0]  == tag_chars_ff[39:32]);
         3'd2:    tag_hit = (window[15:0] == tag_chars_ff[39:24]);
         3'd3:    tag_hit = (window[23:0] == tag_chars_ff[39:16]);
         3'd4:    tag_hit = (window[31:0] == tag_chars_ff[39:8]);
         3'd5:    tag_hit = (window == tag_chars_ff);
         default: tag_hit = 1'b0;
      endcase
   end

   assign store_we = do_store && (c != CHAR_COMMA) && (cc_base == field_index_ff) &&
                     (fl_base < FIELD_LIMIT);

   always_comb begin
      hunting_in      = hunting_ff;
      stored_count_in = stored_count_ff;
      comma_count_in  = comma_count_ff;
      field_length_in = field_length_ff;
      overflow_in     = overflow_ff;
      recent_in       = recent_ff;
      tag_found_in    = tag_found_ff;
      if (cmd.take && ending) begin
         hunting_in = 1'b1;
      end
      if (do_store) begin
         hunting_in      = 1'b0;
         stored_count_in = (sc_base < COUNT_SAT) ? sc_base + 1'b1 : sc_base;
         recent_in       = {rc_base[23:0], c};
         tag_found_in    = tf_base ||
                           ((len_used != '0) &&
                            ({1'b0, stored_count_in} >= {{(COUNT_W+1-LEN_W){1'b0}}, len_used}) &&
                            tag_hit);
         comma_count_in  = cc_base;
         field_length_in = fl_base;
         overflow_in     = ov_base;
         if (c == CHAR_COMMA) begin
            comma_count_in = (cc_base < COUNT_SAT) ? cc_base + 1'b1 : cc_base;
         end else if (cc_base == field_index_ff) begin
            if (fl_base < FIELD_LIMIT) begin
               field_length_in = fl_base + 1'b1;
            end else begin
               overflow_in = 1'b1;
            end
         end
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.take) begin
         idx_in = '0;
      end else if (cmd.inc) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_enable_ff <= 1'b0;
         tag_chars_ff     <= TAG_RESET;
         tag_length_ff    <= TAG_LENGTH_RESET;
         field_index_ff   <= '0;
         hunting_ff       <= 1'b1;
         stored_count_ff  <= '0;
         comma_count_ff   <= '0;
         field_length_ff  <= '0;
         overflow_ff      <= 1'b0;
         recent_ff        <= '0;
         tag_found_ff     <= 1'b0;
         idx_ff           <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_FILTER_ENABLE: filter_enable_ff <= csr_write_data[0];
               REG_TAG_CHARS:     tag_chars_ff     <= csr_write_data[TAG_W-1:0];
               REG_TAG_LENGTH:    tag_length_ff    <= csr_write_data[LEN_W-1:0];
               REG_FIELD_INDEX:   field_index_ff   <= csr_write_data[COUNT_W-1:0];
               default: begin
               end
            endcase
         end
         hunting_ff      <= hunting_in;
         stored_count_ff <= stored_count_in;
         comma_count_ff  <= comma_count_in;
         field_length_ff <= field_length_in;
         overflow_ff     <= overflow_in;
         recent_ff       <= recent_in;
         tag_found_ff    <= tag_found_in;
         idx_ff          <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         field_store[fl_base[AW-1:0]] <= c;
      end
      if (cmd.rd) begin
         rd_data_ff <= field_store[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         char_ff  <= (field_length_ff == '0) ? '0 : rd_data_ff;
         pos_ff   <= POS_W'(idx_ff);
         last_ff  <= sts.last;
         empty_ff <= (field_length_ff == '0);
         trunc_ff <= overflow_ff;
      end
   end

   assign rsp_field_char      = char_ff;
   assign rsp_char_position   = pos_ff;
   assign rsp_last_char       = last_ff;
   assign rsp_field_empty     = empty_ff;
   assign rsp_field_truncated = trunc_ff;

   a_field_length_bound: assert property (@(posedge clock) disable iff (reset)
      field_length_ff <= FIELD_LIMIT)
      else $error("field length exceeds the field store");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> field_length_ff == FIELD_LIMIT)
      else $error("truncation flagged before the field store filled");

   a_line_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, stored_count_ff} < LINE_LIMIT)
      else $error("sentence grew past the line limit");

endmodule

// ===== tb/sv/nmea_sentence_field_extractor_tb.sv =====
`timescale 1ns / 1ps

module nmea_sentence_field_extractor_tb;
   import nsfe_pkg::*;

   // These must match the parameters given to the block below.
   localparam int LINE_LEN      = 128;
   localparam int FIELD_LEN     = 32;
   localparam int TAG_LIMIT     = 5;

   // Random traffic stops once about this many sentence characters have been sent.
   localparam int RANDOM_ITEMS  = 80;
   // Quiet cycles after the last expected character before a register write.
   localparam int SETTLE_CYCLES = 16;
   // Length of the single long receiver stall.
   localparam int HOLD_CYCLES   = 300;
   // A correct run stays far below this limit, so it is only a safety net.
   localparam int CYCLE_LIMIT   = 200000;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [TAG_W-1:0] TAG_RMC = "GPRMC";
   localparam logic [TAG_W-1:0] TAG_GSA = "GNGSA";
   // A zero byte followed by a dollar. With a tag length of two, this could only
   // match across the start of the sentence, which must not count as a match.
   localparam logic [TAG_W-1:0] TAG_ZERO_DOLLAR = {8'h00, CHAR_DOLLAR, 24'h000000};

   // One character of the extracted field, in the order of the result ports.
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic [POS_W-1:0]  pos;
      logic              last;
      logic              empty;
      logic              trunc;
   } field_result_type;

   // Tracks the sentence state and the register settings of the block. It also
   // keeps the field characters that are still expected on the result port.
   class field_extract_predictor;
      logic                 filter_on;
      logic [TAG_W-1:0]     tag;
      logic [LEN_W-1:0]     tag_len;
      logic [COUNT_W-1:0]   field_sel;

      logic                 hunting;
      logic [COUNT_W-1:0]   stored;
      logic [COUNT_W-1:0]   commas;
      logic [CHAR_W-1:0]    field_buf[FIELD_LEN];
      int                   field_len;
      logic                 overflow;
      logic [31:0]          recent;
      logic                 tag_hit;

      field_result_type     expected_chars[$];
      int                   mismatch_count;

      function new();
         filter_on      = 1'b0;
         tag            = TAG_RESET;
         tag_len        = TAG_LENGTH_RESET;
         field_sel      = '0;
         hunting        = 1'b1;
         stored         = '0;
         commas         = '0;
         field_len      = 0;
         overflow       = 1'b0;
         recent         = '0;
         tag_hit        = 1'b0;
         mismatch_count = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         case (idx)
            REG_FILTER_ENABLE: filter_on = data[0];
            REG_TAG_CHARS:     tag       = data[TAG_W-1:0];
            REG_TAG_LENGTH:    tag_len   = data[LEN_W-1:0];
            REG_FIELD_INDEX:   field_sel = data[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      // Notes one accepted character and queues the field characters that it
      // releases, if it ends an accepted sentence.
      function void take_char(logic [CHAR_W-1:0] c);
         int          used;
         logic [63:0] window;
         logic [63:0] mask;
         logic [63:0] want;
         field_result_type r;

         // Tag lengths above the limit act as the full tag.
         used = (int'(tag_len) > TAG_LIMIT) ? TAG_LIMIT : int'(tag_len);

         if (hunting) begin
            if (c != CHAR_DOLLAR) return;
            hunting  = 1'b0;
            stored   = '0;
            commas   = '0;
            field_len = 0;
            overflow = 1'b0;
            recent   = '0;
            tag_hit  = 1'b0;
         end else if (c == CHAR_CR || int'(stored) + 1 >= LINE_LEN) begin
            // The ending character is dropped and takes no part in the checks.
            hunting = 1'b1;
            if (filter_on && !tag_hit && used != 0) return;
            if (field_len == 0) begin
               r = '{ch: '0, pos: '0, last: 1'b1, empty: 1'b1, trunc: 1'b0};
               expected_chars.push_back(r);
            end else begin
               for (int i = 0; i < field_len; i++) begin
                  r.ch    = field_buf[i];
                  r.pos   = POS_W'(i);
                  r.last  = (i + 1 == field_len);
                  r.empty = 1'b0;
                  r.trunc = overflow;
                  expected_chars.push_back(r);
               end
            end
            return;
         end

         if (stored < 7'd127) stored++;

         // The tag may sit anywhere, but only whole within the stored characters.
         if (used > 0 && int'(stored) >= used) begin
            window = {24'd0, recent, c};
            mask   = (64'd1 << (8 * used)) - 64'd1;
            want   = {24'd0, tag} >> (TAG_W - 8 * used);
            if ((window & mask) == want) tag_hit = 1'b1;
         end
         recent = {recent[23:0], c};

         if (c == CHAR_COMMA) begin
            if (commas < 7'd127) commas++;
            return;
         end
         if (commas == field_sel) begin
            if (field_len < FIELD_LEN) begin
               field_buf[field_len] = c;
               field_len++;
            end else begin
               overflow = 1'b1;
            end
         end
      endfunction

      function void check_char(field_result_type got);
         field_result_type want;

         if (expected_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected field character: char %h pos %0d last %b %s %b %s %b",
                        got.ch, got.pos, got.last, "empty", got.empty, "trunc", got.trunc);
            return;
         end
         want = expected_chars.pop_front();
         if (got.ch !== want.ch || got.pos !== want.pos || got.last !== want.last ||
             got.empty !== want.empty || got.trunc !== want.trunc) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("field mismatch: expected char %h pos %0d last %b empty %b trunc %b",
                        want.ch, want.pos, want.last, want.empty, want.trunc);
               $display("                got      char %h pos %0d last %b empty %b trunc %b",
                        got.ch, got.pos, got.last, got.empty, got.trunc);
            end
         end
      endfunction
   endclass

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic [CHAR_W-1:0]    req_rx_byte      = '0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [CHAR_W-1:0]    rsp_field_char;
   logic [POS_W-1:0]     rsp_char_position;
   logic                 rsp_last_char;
   logic                 rsp_field_empty;
   logic                 rsp_field_truncated;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   logic [CSR_W-1:0]     csr_write_data   = '0;

   // When set, the matching side runs without idle cycles for a while.
   bit src_steady   = 1'b0;
   bit sink_steady  = 1'b0;
   // Set for the long receiver stall.
   bit sink_hold    = 1'b0;
   bit random_phase = 1'b0;
   int random_items = 0;
   int cycle_count  = 0;

   field_extract_predictor field_pred;

   nmea_sentence_field_extractor #(
      .LINE_MAX  (LINE_LEN),
      .FIELD_MAX (FIELD_LEN),
      .TAG_MAX   (TAG_LIMIT)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_field_char      (rsp_field_char),
      .rsp_char_position   (rsp_char_position),
      .rsp_last_char       (rsp_last_char),
      .rsp_field_empty     (rsp_field_empty),
      .rsp_field_truncated (rsp_field_truncated),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Safety net against a hung handshake.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Offers one character and returns at the edge where its transaction completes.
   // Valid is left high there, so a following call with no gap keeps it up
   // without a glitch. A caller with nothing more to send lowers it.
   task automatic send_byte(input logic [CHAR_W-1:0] c);
      int gap;
      gap = src_steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= c;
      do @(posedge clock); while (!req_ready);
      field_pred.take_char(c);
   endtask

   // Sends the given text followed by a carriage return.
   task automatic send_sentence(input string text);
      for (int i = 0; i < text.len(); i++) send_byte(text[i]);
      send_byte(CHAR_CR);
   endtask

   // Brings the block back to idle: any open sentence is closed, every expected
   // character is drained, and the emitter gets time to finish any silent work.
   task automatic settle();
      if (!field_pred.hunting) send_byte(CHAR_CR);
      req_valid <= 1'b0;
      while (field_pred.expected_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      field_pred.set_reg(idx, data);
   endtask

   // Writes all four registers on consecutive edges. Call only while idle.
   task automatic configure(input logic fe, input logic [TAG_W-1:0] tag,
                            input logic [LEN_W-1:0] len, input logic [COUNT_W-1:0] sel);
      put_reg(REG_FILTER_ENABLE, CSR_W'(fe));
      put_reg(REG_TAG_CHARS, CSR_W'(tag));
      put_reg(REG_TAG_LENGTH, CSR_W'(len));
      put_reg(REG_FIELD_INDEX, CSR_W'(sel));
      csr_write_enable <= 1'b0;
   endtask

   task automatic configure_random();
      logic [TAG_W-1:0]   tag;
      logic [COUNT_W-1:0] sel;
      int                 pick;
      case ($urandom_range(0, 5))
         0: tag = TAG_RESET;
         1: tag = TAG_RMC;
         2: tag = TAG_GSA;
         3: tag = {8'($urandom), 32'($urandom)};
         4: tag = '0;
         default: tag = '1;
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 7) sel = COUNT_W'($urandom_range(0, 4));
      else if (pick == 7) sel = COUNT_W'($urandom_range(5, 127));
      else if (pick == 8) sel = 7'd127;
      else sel = '0;
      configure(1'($urandom_range(0, 1)), tag, LEN_W'($urandom_range(0, 7)), sel);
   endtask

   // Mostly printable field text; now and then any byte at all, which may be a
   // comma, a dollar, a carriage return or a zero.
   function automatic logic [CHAR_W-1:0] text_char();
      logic [CHAR_W-1:0] c;
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      c = 8'($urandom_range(8'h21, 8'h7E));
      if (c == CHAR_COMMA) c = 8'h2E;
      return c;
   endfunction

   // A well-formed sentence with random content most of the time. Some lose
   // their carriage return so the next dollar lands inside them, and some run
   // past the line length so the block cuts them off.
   task automatic send_random_sentence();
      logic [CHAR_W-1:0] line[$];
      string             header;
      int                nfields;
      int                flen;
      int                ending;
      line.push_back(CHAR_DOLLAR);
      case ($urandom_range(0, 3))
         0: header = "GPGGA";
         1: header = "GPRMC";
         2: header = "GNGSA";
         default: header = "";
      endcase
      if (header.len() == 0) repeat (5) line.push_back(8'($urandom_range(8'h41, 8'h5A)));
      for (int i = 0; i < header.len(); i++) line.push_back(header[i]);
      nfields = $urandom_range(0, 10);
      repeat (nfields) begin
         line.push_back(CHAR_COMMA);
         flen = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 6);
         repeat (flen) line.push_back(text_char());
      end
      ending = $urandom_range(0, 9);
      if (ending < 8) line.push_back(CHAR_CR);
      else if (ending == 9) repeat (LINE_LEN) line.push_back(text_char());
      src_steady = ($urandom_range(0, 3) == 0);
      foreach (line[i]) send_byte(line[i]);
      random_items += line.size();
   endtask

   // Receiver: accepts field characters with random pauses and checks each one
   // against the oldest expected character.
   initial begin
      int               gap;
      field_result_type got;
      wait (reset == 1'b0);
      forever begin
         gap = sink_steady ? 0 : $urandom_range(0, 3);
         if (gap > 0 || sink_hold) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
            while (sink_hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got = {rsp_field_char, rsp_char_position, rsp_last_char, rsp_field_empty,
                rsp_field_truncated};
         field_pred.check_char(got);
         if ($urandom_range(0, 15) == 0) sink_steady = !sink_steady;
      end
   end

   // One long receiver stall early in the random traffic. The sender keeps
   // offering characters, so the block has to hold its input back.
   initial begin
      wait (random_phase);
      repeat (30) @(posedge clock);
      sink_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      sink_hold = 1'b0;
   end

   initial begin
      int sentence_count;
      field_pred = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: raw mode and the leading field, which includes the dollar.
      // Stray characters before the first dollar are skipped.
      send_byte(8'h41);
      send_byte(CHAR_CR);
      send_sentence("$GPGGA,123,N");
      // A zero byte, a dollar inside the sentence and the top byte value are all
      // stored as ordinary characters.
      send_byte(CHAR_DOLLAR);
      send_byte(8'h00);
      send_byte(CHAR_DOLLAR);
      send_byte(8'hFF);
      send_byte(CHAR_COMMA);
      send_byte(8'h80);
      send_byte(CHAR_CR);
      settle();

      // Filtered on the reset tag. Two commas in a row give an empty field, and
      // a sentence without the tag is dropped silently.
      configure(1'b1, TAG_RESET, 3'd5, 7'd2);
      send_sentence("$GPGGA,A,,B");
      send_sentence("$GPRMC,A,B,C");
      settle();

      // An empty tag always matches. A field index past the last field is empty.
      configure(1'b1, TAG_RMC, 3'd0, 7'd127);
      send_sentence("$X,Y");
      settle();

      // A tag that would only match across the sentence start is not a match.
      // The same pair later inside the sentence is.
      configure(1'b1, TAG_ZERO_DOLLAR, 3'd2, 7'd1);
      send_sentence("$AB,CD");
      send_byte(CHAR_DOLLAR);
      send_byte(8'h41);
      send_byte(8'h00);
      send_byte(CHAR_DOLLAR);
      send_byte(CHAR_COMMA);
      send_byte(8'h51);
      send_byte(CHAR_CR);
      settle();

      // An oversized tag length acts as the full tag, so a partial tag is not enough.
      configure(1'b1, TAG_RESET, 3'd7, 7'd1);
      send_sentence("$GPGGA,7");
      send_sentence("$GPGG,7");
      settle();

      // A line with no carriage return is cut at the line length, and its long
      // field is truncated to the field size. The remaining digits are skipped.
      configure(1'b0, '1, 3'd1, 7'd1);
      send_byte(CHAR_DOLLAR);
      send_byte(CHAR_COMMA);
      for (int i = 0; i < LINE_LEN + 2; i++) send_byte(8'h30 + 8'(i % 10));
      settle();

      // Random traffic, with a fresh setting every few sentences.
      random_phase   = 1'b1;
      sentence_count = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (sentence_count % 5 == 0) begin
            settle();
            configure_random();
         end
         src_steady = 1'b0;
         repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
         send_random_sentence();
         sentence_count++;
      end
      settle();

      if (field_pred.mismatch_count == 0 && field_pred.expected_chars.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/nsfe_pkg.sv
hdl/nsfe_ctrl.sv
hdl/nsfe_datapath.sv
hdl/nmea_sentence_field_extractor.sv
tb/sv/nmea_sentence_field_extractor_tb.sv
